// ----- sv/totp_pkg.sv -----
// shared constants and sha-1 round helpers for the totp code block
`timescale 1ns / 1ps
package totp_pkg;

	localparam int KEY_WORDS  = 8;
	localparam int KEY_W      = 64;
	localparam int CFG_IDX_W  = 4;
	localparam int SECS_W     = 31;
	localparam int CODE_W     = 20;
	localparam int EXPIRE_W   = 32;
	localparam int DIGEST_W   = 160;
	localparam int BLOCK_W    = 512;
	localparam int SHA_ROUNDS = 80;

	localparam int DEF_TIME_STEP = 30;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5C;
	localparam logic [30:0] TRUNC_MASK = 31'h7FFF_FFFF;

	// sha-1 initial chaining value, h0 in the top bits
	localparam logic [DIGEST_W-1:0] SHA1_IV =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

	// padding words for the two second blocks
	localparam logic [31:0] PAD_ONE_WORD  = 32'h8000_0000;
	localparam logic [31:0] INNER_LEN_BITS = 32'd576;
	localparam logic [31:0] OUTER_LEN_BITS = 32'd672;

	// reduction modulo one million by reciprocal multiply (exact for 31-bit values)
	localparam int          CODE_MOD     = 1000000;
	localparam int          MOD_SHIFT    = SECS_W + $clog2(CODE_MOD);
	localparam logic [63:0] MOD_MUL_WIDE = ((64'd1 << MOD_SHIFT) + 64'(CODE_MOD) - 64'd1)
		/ 64'(CODE_MOD);
	localparam logic [31:0] MOD_MUL      = MOD_MUL_WIDE[31:0];
	localparam int          MOD_Q_W      = 12;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] sha_k(input int r);
		if (r < 20) begin
			sha_k = 32'h5A827999;
		end else if (r < 40) begin
			sha_k = 32'h6ED9EBA1;
		end else if (r < 60) begin
			sha_k = 32'h8F1BBCDC;
		end else begin
			sha_k = 32'hCA62C1D6;
		end
	endfunction

	function automatic logic [31:0] sha_f(input int r, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		if (r < 20) begin
			sha_f = (b & c) | (~b & d);
		end else if (r < 40) begin
			sha_f = b ^ c ^ d;
		end else if (r < 60) begin
			sha_f = (b & c) | (b & d) | (c & d);
		end else begin
			sha_f = b ^ c ^ d;
		end
	endfunction

endpackage

// ----- sv/totp_hmac_sha1_code_top.sv -----
// totp code generator: time step, hmac-sha1 over four sha-1 blocks, truncation, mod 1e6
// pipeline: 2 counter stages + 4 x 82 sha-1 stages + 4 truncation stages
// throughput: one request per cycle; all stages move together and hold on output stall
// most stages come from the four unrolled sha-1 compressions, one round per stage
// reset: arst_n clears all valid bits and the key registers (key reads as all zero)
`timescale 1ns / 1ps
module totp_hmac_sha1_code_top
	import totp_pkg::*;
#(
	parameter int TIME_STEP = DEF_TIME_STEP
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data,
	// input requests
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // [30:0] unix_seconds
	// output results
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [55:0]          m_tdata    // [19:0] otp_code, [51:20] expire_seconds
);

	// reciprocal for division by the time step (exact over 31-bit inputs)
	localparam int          TS_W        = $clog2(TIME_STEP + 1);
	localparam int          TS_SHIFT    = SECS_W + $clog2(TIME_STEP);
	localparam logic [63:0] TS_MUL_WIDE = ((64'd1 << TS_SHIFT) + 64'(TIME_STEP) - 64'd1)
		/ 64'(TIME_STEP);
	localparam logic [31:0] TS_MUL      = TS_MUL_WIDE[31:0];
	localparam logic [TS_W-1:0] TS_VAL  = TS_W'(TIME_STEP);

	localparam int SIDE1_W = SECS_W + EXPIRE_W;
	localparam int SIDE3_W = DIGEST_W + EXPIRE_W;

	// global advance: everything moves unless the output holds an untaken result
	logic adv;

	logic [KEY_W-1:0] key_q [0:KEY_WORDS-1];
	logic [KEY_W*KEY_WORDS-1:0] key_flat;

	// counter stage signals
	logic        vld_s1, vld_s2;
	logic [62:0] prod_s1;
	logic [SECS_W-1:0]   cnt_s2;
	logic [EXPIRE_W-1:0] exp_s2;
	logic [SECS_W-1:0]   cnt_c;

	// sha block outputs
	logic                b1_vld, b2_vld, b3_vld, b4_vld;
	logic [DIGEST_W-1:0] b1_h, b2_h, b3_h, b4_h;
	logic [SIDE1_W-1:0]  b1_side, b2_side;
	logic [SIDE3_W-1:0]  b3_side;
	logic [EXPIRE_W-1:0] b4_side;
	logic [BLOCK_W-1:0]  blk1, blk2, blk3, blk4;

	// truncation and reduction stages
	logic                vld_t1, vld_t2, vld_t3, vld_t4;
	logic [30:0]         bin_t1, bin_t2, bin_t3;
	logic [62:0]         qprod_t2;
	logic [31:0]         qm_t3;
	logic [CODE_W-1:0]   code_t4;
	logic [EXPIRE_W-1:0] exp_t1, exp_t2, exp_t3, exp_t4;
	logic [DIGEST_W-1:0] dig_shift;
	logic [MOD_Q_W-1:0]  q_mod;

	assign adv       = !vld_t4 || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// key registers; writes beyond the key words are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_valid && (cfg_index < CFG_IDX_W'(KEY_WORDS))) begin
			key_q[cfg_index[$clog2(KEY_WORDS)-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < KEY_WORDS; i++) begin
			key_flat[KEY_W*(KEY_WORDS-i)-1 -: KEY_W] = key_q[i];
		end
	end

	// stage 1: seconds times reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	// product stays below 2^63, so the shifted quotient fits the seconds width
	assign cnt_c = SECS_W'(prod_s1 >> TS_SHIFT);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= 63'(s_tdata[SECS_W-1:0]) * 63'(TS_MUL);
			// stage 2: time-step counter and end of its window
			cnt_s2  <= cnt_c;
			exp_s2  <= EXPIRE_W'((EXPIRE_W'(cnt_c) + EXPIRE_W'(1)) * EXPIRE_W'(TS_VAL));
		end
	end

	// inner pad block, then counter block (8 bytes big-endian, padded, length 72 bytes)
	assign blk1 = key_flat ^ {64{IPAD_BYTE}};
	assign blk2 = {32'd0, 1'b0, b1_side[SIDE1_W-1 -: SECS_W], PAD_ONE_WORD,
		{12{32'd0}}, INNER_LEN_BITS};
	// outer pad block, then inner hash block (length 84 bytes)
	assign blk3 = key_flat ^ {64{OPAD_BYTE}};
	assign blk4 = {b3_side[SIDE3_W-1 -: DIGEST_W], PAD_ONE_WORD, {9{32'd0}}, OUTER_LEN_BITS};

	totp_sha1_blk #(.SIDE_W(SIDE1_W)) u_inner_key (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(vld_s2), .in_block(blk1), .in_h(SHA1_IV), .in_side({cnt_s2, exp_s2}),
		.out_valid(b1_vld), .out_h(b1_h), .out_side(b1_side)
	);

	totp_sha1_blk #(.SIDE_W(SIDE1_W)) u_inner_msg (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(b1_vld), .in_block(blk2), .in_h(b1_h), .in_side(b1_side),
		.out_valid(b2_vld), .out_h(b2_h), .out_side(b2_side)
	);

	totp_sha1_blk #(.SIDE_W(SIDE3_W)) u_outer_key (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(b2_vld), .in_block(blk3), .in_h(SHA1_IV),
		.in_side({b2_h, b2_side[EXPIRE_W-1:0]}),
		.out_valid(b3_vld), .out_h(b3_h), .out_side(b3_side)
	);

	totp_sha1_blk #(.SIDE_W(EXPIRE_W)) u_outer_msg (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(b3_vld), .in_block(blk4), .in_h(b3_h), .in_side(b3_side[EXPIRE_W-1:0]),
		.out_valid(b4_vld), .out_h(b4_h), .out_side(b4_side)
	);

	// dynamic truncation: low nibble of the last byte picks a 4-byte window
	assign dig_shift = b4_h << {b4_h[3:0], 3'b000};
	assign q_mod     = qprod_t2[MOD_SHIFT +: MOD_Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t1 <= 1'b0;
			vld_t2 <= 1'b0;
			vld_t3 <= 1'b0;
			vld_t4 <= 1'b0;
		end else if (adv) begin
			vld_t1 <= b4_vld;
			vld_t2 <= vld_t1;
			vld_t3 <= vld_t2;
			vld_t4 <= vld_t3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_t1   <= dig_shift[DIGEST_W-2 -: 31] & TRUNC_MASK;
			exp_t1   <= b4_side;
			// reciprocal multiply for the quotient by one million
			qprod_t2 <= 63'(bin_t1) * 63'(MOD_MUL);
			bin_t2   <= bin_t1;
			exp_t2   <= exp_t1;
			// quotient back to a multiple of one million
			qm_t3    <= 32'(q_mod) * 32'(CODE_MOD);
			bin_t3   <= bin_t2;
			exp_t3   <= exp_t2;
			// remainder is the code
			code_t4  <= CODE_W'(32'(bin_t3) - qm_t3);
			exp_t4   <= exp_t3;
		end
	end

	assign m_tvalid = vld_t4;
	assign m_tdata  = {4'd0, exp_t4, code_t4};

endmodule

// ----- sv/totp_sha1_blk.sv -----
// one sha-1 compression, one round per pipeline stage, with a side-data lane
`timescale 1ns / 1ps
module totp_sha1_blk
	import totp_pkg::*;
#(
	parameter int SIDE_W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [BLOCK_W-1:0]  in_block,
	input  logic [DIGEST_W-1:0] in_h,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [DIGEST_W-1:0] out_h,
	output logic [SIDE_W-1:0]   out_side
);

	logic                vld_s  [0:SHA_ROUNDS];
	logic [31:0]         a_s    [0:SHA_ROUNDS];
	logic [31:0]         b_s    [0:SHA_ROUNDS];
	logic [31:0]         c_s    [0:SHA_ROUNDS];
	logic [31:0]         d_s    [0:SHA_ROUNDS];
	logic [31:0]         e_s    [0:SHA_ROUNDS];
	logic [31:0]         w_s    [0:SHA_ROUNDS][0:15];
	logic [DIGEST_W-1:0] h_s    [0:SHA_ROUNDS];
	logic [SIDE_W-1:0]   side_s [0:SHA_ROUNDS];

	logic                vld_sf;
	logic [DIGEST_W-1:0] dig_sf;
	logic [SIDE_W-1:0]   side_sf;

	// load stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0]    <= in_h[159:128];
			b_s[0]    <= in_h[127:96];
			c_s[0]    <= in_h[95:64];
			d_s[0]    <= in_h[63:32];
			e_s[0]    <= in_h[31:0];
			h_s[0]    <= in_h;
			side_s[0] <= in_side;
			for (int j = 0; j < 16; j++) begin
				w_s[0][j] <= in_block[BLOCK_W-1-32*j -: 32];
			end
		end
	end

	// round stages
	for (genvar r = 0; r < SHA_ROUNDS; r++) begin : g_round
		logic [31:0] t;
		logic [31:0] w_new;

		assign t = rotl(a_s[r], 5) + sha_f(r, b_s[r], c_s[r], d_s[r]) + e_s[r]
			+ sha_k(r) + w_s[r][0];
		assign w_new = rotl(w_s[r][13] ^ w_s[r][8] ^ w_s[r][2] ^ w_s[r][0], 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r+1] <= 1'b0;
			end else if (en) begin
				vld_s[r+1] <= vld_s[r];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[r+1]    <= t;
				b_s[r+1]    <= a_s[r];
				c_s[r+1]    <= rotl(b_s[r], 30);
				d_s[r+1]    <= c_s[r];
				e_s[r+1]    <= d_s[r];
				h_s[r+1]    <= h_s[r];
				side_s[r+1] <= side_s[r];
				for (int j = 0; j < 15; j++) begin
					w_s[r+1][j] <= w_s[r][j+1];
				end
				w_s[r+1][15] <= w_new;
			end
		end
	end

	// chaining add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_sf <= vld_s[SHA_ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dig_sf <= {h_s[SHA_ROUNDS][159:128] + a_s[SHA_ROUNDS],
				h_s[SHA_ROUNDS][127:96] + b_s[SHA_ROUNDS],
				h_s[SHA_ROUNDS][95:64]  + c_s[SHA_ROUNDS],
				h_s[SHA_ROUNDS][63:32]  + d_s[SHA_ROUNDS],
				h_s[SHA_ROUNDS][31:0]   + e_s[SHA_ROUNDS]};
			side_sf <= side_s[SHA_ROUNDS];
		end
	end

	assign out_valid = vld_sf;
	assign out_h     = dig_sf;
	assign out_side  = side_sf;

endmodule

// ----- tb/sv/tb_totp_hmac_sha1_code_top.sv -----
// testbench for the totp hmac-sha1 code block: random times and keys, scoreboard checks
`timescale 1ns / 1ps
module tb_totp_hmac_sha1_code_top
	import totp_pkg::*;
();

	localparam int LATENCY    = 334;
	localparam int RAND_ITEMS = 1030;
	localparam longint CYCLE_LIMIT = 400000;

	// key index codes; one past the end exercises the ignored write
	typedef enum logic [CFG_IDX_W-1:0] {
		KEY_IDX_0 = 4'd0, KEY_IDX_1 = 4'd1, KEY_IDX_2 = 4'd2, KEY_IDX_7 = 4'd7,
		KEY_IDX_BAD = 4'd8, KEY_IDX_TOP = 4'd15
	} key_idx_e;

	typedef struct packed {
		logic [EXPIRE_W-1:0] expire;
		logic [CODE_W-1:0]   code;
	} otp_result_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0] cfg_data;
	logic s_tvalid, s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [55:0] m_tdata;

	// reference copy of the secret
	logic [KEY_W-1:0] secret [KEY_WORDS];
	longint cycles;

	totp_hmac_sha1_code_top dut (.*);

	// ---------------- hmac-sha1 predictor ----------------
	function automatic logic [31:0] rol32(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [159:0] compress(logic [159:0] hv, logic [511:0] blk);
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		a = hv[159:128]; b = hv[127:96]; c = hv[95:64]; d = hv[63:32]; e = hv[31:0];
		for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
		for (int i = 16; i < 80; i++)
			w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rol32(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rol32(b, 30); b = a; a = t;
		end
		return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d,
			hv[31:0] + e};
	endfunction

	function automatic otp_result_t predict_otp(logic [30:0] secs);
		logic [511:0] keyblk, ipad, opad, tail;
		logic [63:0] step_cnt;
		logic [159:0] ihash, dig;
		logic [7:0] db [20];
		logic [3:0] off;
		logic [31:0] bin;
		otp_result_t r;
		for (int i = 0; i < KEY_WORDS; i++) keyblk[511 - 64*i -: 64] = secret[i];
		ipad = keyblk ^ {64{8'h36}};
		opad = keyblk ^ {64{8'h5C}};
		step_cnt = 64'(secs) / 64'(DEF_TIME_STEP);
		tail = {step_cnt, 32'h8000_0000, 352'd0, 64'd576};
		ihash = compress(compress(160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0, ipad),
			tail);
		tail = {ihash, 32'h8000_0000, 256'd0, 64'd672};
		dig = compress(compress(160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0, opad),
			tail);
		for (int i = 0; i < 20; i++) db[i] = dig[159 - 8*i -: 8];
		off = db[19][3:0];
		bin = {1'b0, db[off][6:0], db[off+1], db[off+2], db[off+3]};
		r.code = 20'(bin % 1000000);
		r.expire = 32'((step_cnt + 1) * DEF_TIME_STEP);
		return r;
	endfunction

	// ---------------- scoreboard ----------------
	class otp_scoreboard;
		otp_result_t pending_codes[$];
		int errors;
		function void note_request(otp_result_t exp_r);
			pending_codes.push_back(exp_r);
		endfunction
		function void check_result(logic [55:0] data);
			otp_result_t exp_r, got;
			got = data[51:0];
			if (pending_codes.size() == 0) begin
				$display("%0t: unexpected result code=%0d expire=%0d", $time, got.code,
					got.expire);
				errors++;
				return;
			end
			exp_r = pending_codes.pop_front();
			if (got.code !== exp_r.code) begin
				$display("%0t: otp_code expected %0d actual %0d", $time, exp_r.code, got.code);
				errors++;
			end
			if (got.expire !== exp_r.expire) begin
				$display("%0t: expire_seconds expected %0d actual %0d", $time, exp_r.expire,
					got.expire);
				errors++;
			end
		endfunction
	endclass

	otp_scoreboard sb;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: stall pattern of its own, with quiet stretches of no stalls
	initial begin
		int mode;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if ((cycles % 2000) == 0) mode = $urandom_range(0, 2);
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ((cycles % 7) < 3);
			endcase
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// configuration write; caller guarantees the pipe is empty
	task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx < KEY_WORDS) secret[idx] = val;
		@(posedge clk);
	endtask

	// send one request, with burst-gap idling handled by the caller
	task automatic send_time(logic [31:0] t);
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		do @(posedge clk); while (!s_tready);
		sb.note_request(predict_otp(t[30:0]));
	endtask

	task automatic idle_cycles(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait for the pipe to empty, then idle for longer than its latency
	task automatic drain_pipe();
		idle_cycles(1);
		while (sb.pending_codes.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic random_burst_run(int n, int mode);
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 12));
			end
			burst--;
			case (mode)
				0: send_time($urandom);
				1: send_time({1'b0, 31'($urandom_range(0, 60))});
				default: send_time({1'($urandom), 31'h7FFF_FFFF - 31'($urandom_range(0, 90))});
			endcase
		end
	endtask

	initial begin
		logic [KEY_W-1:0] rk;
		sb = new();
		for (int i = 0; i < KEY_WORDS; i++) secret[i] = '0;
		arst_n = 0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		s_tvalid = 0; s_tdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset key (all zero), field extremes, step boundaries, high bit ignored
		send_time(32'd0);
		send_time(32'd29);
		send_time(32'd30);
		send_time(32'd59);
		send_time(32'h7FFF_FFFF);
		send_time(32'hFFFF_FFFF);
		send_time(32'h8000_0000);
		send_time(32'h5555_5555);
		send_time(32'h2AAA_AAAA);
		drain_pipe();

		// rfc-style ascii secret "12345678901234567890", zero padded
		write_key(KEY_IDX_0, 64'h31323334_35363738);
		write_key(KEY_IDX_1, 64'h39303132_33343536);
		write_key(KEY_IDX_2, 64'h37383930_00000000);
		for (int i = 3; i <= KEY_IDX_7; i++) write_key(i[3:0], '0);
		write_key(KEY_IDX_BAD, 64'hDEAD_BEEF_0000_0001);   // ignored index
		write_key(KEY_IDX_TOP, '1);
		send_time(32'd59);
		send_time(32'd1111111109);
		send_time(32'd1234567890);
		send_time(32'd2000000000);
		drain_pipe();

		// all-ones key extreme
		for (int i = 0; i < KEY_WORDS; i++) write_key(i[3:0], '1);
		send_time(32'd0);
		send_time(32'h7FFF_FFFF);
		send_time(32'd12345);
		idle_cycles(3);
		send_time(32'd30);
		drain_pipe();

		// random keys across phases
		for (int ph = 0; ph < 5; ph++) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				rk = {$urandom, $urandom};
				if (ph == 4 && i > 2) rk = '0;
				write_key(i[3:0], rk);
			end
			write_key(4'($urandom_range(KEY_WORDS, 15)), {$urandom, $urandom});
			random_burst_run(RAND_ITEMS / 5, ph % 3);
			// sender pause until everything is back
			drain_pipe();
		end

		drain_pipe();
		if (sb.errors == 0 && sb.pending_codes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/totp_pkg.sv
sv/totp_sha1_blk.sv
sv/totp_hmac_sha1_code_top.sv
tb/sv/tb_totp_hmac_sha1_code_top.sv
